[hdl/lpt_pkg.sv]
// Shared types, constants and helpers for the LPT partition block.
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

    localparam int LOAD_BITS = 22;
    localparam int IDX_BITS  = 6;

    // Controller state.
    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } t_state;

    // Operation applied to every cell of the weight chain in the same cycle.
    typedef enum logic [1:0] {
        W_HOLD,
        W_INSERT,
        W_SHIFT
    } t_wop;

    // Operation applied to every cell of the group chain in the same cycle.
    typedef enum logic [1:0] {
        G_HOLD,
        G_CLEAR,
        G_SEED,
        G_REPLACE
    } t_gop;

    // One group entry: its running load and its group number.
    typedef struct packed {
        logic                 valid;
        logic [LOAD_BITS-1:0] sum;
        logic [IDX_BITS-1:0]  idx;
    } t_gent;

    typedef struct packed {
        logic [15:0] weight;
        logic        set_end;
    } t_in;

    typedef struct packed {
        logic [15:0]          sorted_weight;
        logic [3:0]           group_index;
        logic [LOAD_BITS-1:0] group_load;
        logic                 dropped_items;
        logic                 run_end;
    } t_out;

    // Load plus weight, saturating at the largest load value.
    function automatic logic [LOAD_BITS-1:0] add_sat(input logic [LOAD_BITS-1:0] a,
                                                     input logic [15:0] b);
        logic [LOAD_BITS:0] s;
        s = {1'b0, a} + (LOAD_BITS + 1)'(b);
        return s[LOAD_BITS] ? {LOAD_BITS{1'b1}} : s[LOAD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/lpt_wcell.sv]
// One cell of the descending weight sorting chain.
`timescale 1ns / 1ps
`default_nettype none

module lpt_wcell #(
    parameter int WB = 16
) (
    input  wire logic           i_clk,
    input  wire lpt_pkg::t_wop  i_op,
    input  wire logic           i_occ,
    input  wire logic [WB-1:0]  i_new,
    input  wire logic [WB-1:0]  i_prev_w,
    input  wire logic           i_prev_gt,
    input  wire logic [WB-1:0]  i_next_w,
    output logic      [WB-1:0]  o_w,
    output logic                o_gt
);
    import lpt_pkg::*;

    logic [WB-1:0] r_w;
    logic [WB-1:0] n_w;

    // The cell keeps its weight when it is at least the incoming one.
    assign o_gt = i_occ && (r_w >= i_new);
    assign o_w  = r_w;

    always_comb begin
        n_w = r_w;
        unique case (i_op)
            W_INSERT: begin
                if (o_gt) begin
                    n_w = r_w;
                end else if (i_prev_gt) begin
                    n_w = i_new;
                end else begin
                    n_w = i_prev_w;
                end
            end
            W_SHIFT: n_w = i_next_w;
            default: n_w = r_w;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

endmodule

`default_nettype wire

[hdl/lpt_gcell.sv]
// One cell of the group chain, kept in ascending order of load and index.
`timescale 1ns / 1ps
`default_nettype none

module lpt_gcell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lpt_pkg::t_gop   i_op,
    input  wire logic            i_head,
    input  wire lpt_pkg::t_gent  i_key,
    input  wire lpt_pkg::t_gent  i_prev,
    input  wire logic            i_prev_lt,
    input  wire lpt_pkg::t_gent  i_next,
    input  wire logic            i_next_lt,
    output lpt_pkg::t_gent       o_ent,
    output logic                 o_lt
);
    import lpt_pkg::*;

    t_gent r_ent;
    t_gent n_ent;

    // Ordering key is the load first, the group number breaking ties.
    assign o_lt  = r_ent.valid && ({r_ent.sum, r_ent.idx} < {i_key.sum, i_key.idx});
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        unique case (i_op)
            G_CLEAR: n_ent.valid = 1'b0;
            G_SEED: begin
                if (o_lt) begin
                    n_ent = r_ent;
                end else if (i_head || i_prev_lt) begin
                    n_ent = i_key;
                end else begin
                    n_ent = i_prev;
                end
            end
            G_REPLACE: begin
                // The head leaves; smaller entries move up, the key drops in.
                if (i_next_lt) begin
                    n_ent = i_next;
                end else if (i_head || o_lt) begin
                    n_ent = i_key;
                end else begin
                    n_ent = r_ent;
                end
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule

`default_nettype wire

[hdl/greedy_lpt_partition_core.sv]
// Top level of the greedy longest-processing-time-first partition block.
// Usage:
//   Weights arrive as requests on the input channel (valid/ready). Each one
//   drops straight into a chain of sorting cells, so a set loads at one
//   weight per cycle. Weights beyond MAX_ITEMS are discarded and flagged.
//   The request marked set_end closes the set. Once the state register has
//   switched to emitting, the head of the chain (the largest weight) is
//   popped each cycle the output can take it, assigned to a group and
//   registered on the output channel; a second chain of group cells keeps
//   the groups ordered by load, so its head is always the least loaded
//   group with the lowest index. One result per stored weight follows in
//   descending order, the last one with run_end set. The input is not ready
//   while a set is being emitted; a stalled receiver holds the output
//   register and freezes both chains. group_count is sampled when set_end
//   is accepted and must only be written while the block is idle.
//   Reset (synchronous, active low) empties both chains, restores
//   group_count to 16 and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none

module greedy_lpt_partition_core #(
    parameter int MAX_ITEMS   = 64,
    parameter int MAX_GROUPS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire lpt_pkg::t_in    i_in_req,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output lpt_pkg::t_out        o_out_req,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [4:0]      i_cfg_wr_data
);
    import lpt_pkg::*;

    // Stored weights are never wider than the 16-bit input field.
    localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int GC_W  = $clog2(MAX_GROUPS + 1);

    t_state            r_state, n_state;
    logic [4:0]        r_cfg;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [GC_W-1:0]   r_gact, n_gact;
    logic              r_out_valid;
    t_out              r_out, n_out;

    logic              w_in_acc;
    logic              w_full;
    logic              w_step;
    logic              w_seed;
    logic              w_last;
    logic [WB-1:0]     w_new;
    logic [WB-1:0]     w_head;
    logic [GC_W-1:0]   w_gsel;
    t_gent             w_key;
    t_wop              w_wop;
    t_gop              w_gop;

    logic [WB-1:0]     w_w  [MAX_ITEMS];
    logic              w_gt [MAX_ITEMS];
    t_gent             w_g  [MAX_GROUPS];
    logic              w_lt [MAX_GROUPS];

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_full   = 32'(r_count) >= 32'(MAX_ITEMS);
    assign w_new    = i_in_req.weight[WB-1:0];
    assign w_step   = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign w_seed   = 32'(r_idx) < 32'(r_gact);
    assign w_last   = r_count == CNT_W'(1);
    assign w_head   = w_w[0];

    // Group count: zero acts as one, large values clip to MAX_GROUPS.
    always_comb begin
        priority if (r_cfg == 5'd0) begin
            w_gsel = GC_W'(1);
        end else if (32'(r_cfg) > 32'(MAX_GROUPS)) begin
            w_gsel = GC_W'(MAX_GROUPS);
        end else begin
            w_gsel = GC_W'(r_cfg);
        end
    end

    // The first group_count weights seed groups in order; later ones go to
    // the head of the group chain, which is the least loaded group.
    always_comb begin
        w_key.valid = 1'b1;
        if (w_seed) begin
            w_key.sum = LOAD_BITS'(w_head);
            w_key.idx = IDX_BITS'(r_idx);
        end else begin
            w_key.sum = add_sat(w_g[0].sum, 16'(w_head));
            w_key.idx = w_g[0].idx;
        end
    end

    // Chain operations.
    always_comb begin
        priority if (w_in_acc && !w_full) begin
            w_wop = W_INSERT;
        end else if (w_step) begin
            w_wop = W_SHIFT;
        end else begin
            w_wop = W_HOLD;
        end
    end

    always_comb begin
        priority if (w_in_acc && i_in_req.set_end) begin
            w_gop = G_CLEAR;
        end else if (w_step) begin
            w_gop = w_seed ? G_SEED : G_REPLACE;
        end else begin
            w_gop = G_HOLD;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: if (w_in_acc && i_in_req.set_end) n_state = ST_RUN;
            ST_RUN:  if (w_step && w_last) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // State outputs.
    always_comb begin
        unique case (r_state)
            ST_LOAD: o_in_ready = 1'b1;
            ST_RUN:  o_in_ready = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // Counters and set bookkeeping.
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_gact  = r_gact;
        if (w_in_acc) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            if (i_in_req.set_end) begin
                n_idx  = '0;
                n_gact = w_gsel;
            end
        end else if (w_step) begin
            n_count = r_count - CNT_W'(1);
            n_idx   = r_idx + CNT_W'(1);
            if (w_last) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_comb begin
        n_out.sorted_weight = 16'(w_head);
        n_out.group_index   = 4'(w_key.idx);
        n_out.group_load    = w_key.sum;
        n_out.dropped_items = r_ovf;
        n_out.run_end       = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cfg       <= 5'd16;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_gact      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_gact  <= n_gact;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Weight chain: cell 0 holds the largest weight.
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_wchain
        logic [WB-1:0] w_prev_w;
        logic          w_prev_gt;
        logic [WB-1:0] w_next_w;
        if (k == 0) begin : g_first
            assign w_prev_w  = w_new;
            assign w_prev_gt = 1'b1;
        end else begin : g_mid
            assign w_prev_w  = w_w[k-1];
            assign w_prev_gt = w_gt[k-1];
        end
        if (k == MAX_ITEMS - 1) begin : g_end
            assign w_next_w = '0;
        end else begin : g_inner
            assign w_next_w = w_w[k+1];
        end
        lpt_wcell #(
            .WB(WB)
        ) u_wcell (
            .i_clk     (i_clk),
            .i_op      (w_wop),
            .i_occ     (32'(r_count) > k),
            .i_new     (w_new),
            .i_prev_w  (w_prev_w),
            .i_prev_gt (w_prev_gt),
            .i_next_w  (w_next_w),
            .o_w       (w_w[k]),
            .o_gt      (w_gt[k])
        );
    end

    // Group chain: cell 0 holds the least loaded group.
    for (genvar k = 0; k < MAX_GROUPS; k++) begin : g_gchain
        t_gent w_prev;
        logic  w_prev_lt;
        t_gent w_next;
        logic  w_next_lt;
        if (k == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_lt = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_g[k-1];
            assign w_prev_lt = w_lt[k-1];
        end
        if (k == MAX_GROUPS - 1) begin : g_end
            assign w_next    = '0;
            assign w_next_lt = 1'b0;
        end else begin : g_inner
            assign w_next    = w_g[k+1];
            assign w_next_lt = w_lt[k+1];
        end
        lpt_gcell u_gcell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (w_gop),
            .i_head    (k == 0),
            .i_key     (w_key),
            .i_prev    (w_prev),
            .i_prev_lt (w_prev_lt),
            .i_next    (w_next),
            .i_next_lt (w_next_lt),
            .o_ent     (w_g[k]),
            .o_lt      (w_lt[k])
        );
    end

`ifndef SYNTH
    // A set being emitted always has stored weights left.
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_count != '0))
        else $error("emission with an empty weight chain");

    // Once every group is seeded, the chain head must be a live group.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !w_seed) |-> w_g[0].valid)
        else $error("least loaded group missing after seeding");

    // The last result returns the block to loading with a clean set.
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_last) |=> (r_state == ST_LOAD && r_count == '0 && !r_ovf))
        else $error("set state not cleared after the last result");

    // The two leading cells of the weight chain stay in descending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) >= 2) |-> (w_w[0] >= w_w[1]))
        else $error("weight chain out of order");
`endif

endmodule

`default_nettype wire
